// ===== src/line_rasterizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_TOP_DEFINES_SVH
`define LINE_RASTERIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("line rasterizer check failed");
`define LR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");
`define LR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");
`else
`define LR_ASSERT(lbl, expr)
`define LR_ASSERT_IMP(lbl, ante, cons)
`define LR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, request and result types, and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int RGB_BITS   = 24;
  localparam int COLOR_BITS = 16;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } lr_op_e;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    lr_op_e                op;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    logic [RGB_BITS-1:0]   rgb_color;
  } lr_in_t;

  typedef struct packed {
    logic                  pixel_valid;
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } lr_out_t;

  // Classified request as it sits in the queue: start requests carry their
  // precomputed line setup.
  typedef struct packed {
    lr_op_e                op;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    coord_t                delta_x;
    coord_t                delta_y;
    logic                  step_x_neg;
    logic                  step_y_neg;
    err_t                  error_init;
    logic [COLOR_BITS-1:0] color;
  } lr_cmd_t;

endpackage

`default_nettype wire

// ===== src/line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Bresenham line walker producing one RGB565 pixel result per request.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o / in_data_i) takes one
// request per handshake. A start request carries both endpoints and a 24-bit
// color and yields the first pixel; each advance request yields the next
// pixel of the current line. Every request produces exactly one result on the
// output channel (out_valid_o / out_ready_i / out_data_o). The endpoint pixel
// has last set and ends the line; an advance with no line in progress returns
// a result with pixel_valid clear and all other fields zero.
// A request accepted at the input is written into the queue and moves on into
// the output register once it heads the queue and the output register is free.
// Throughput is one request per cycle while out_ready_i stays high; the walker's
// single-step add and compare in the back end sets that figure.
// Reset clears the line state (no line active), the two-entry request queue and
// the output valid flag. When the receiver stalls, the result holds in the
// output register, the walker stops, and the queue absorbs up to two more
// requests before in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_rasterizer_top_defines.svh"

module line_rasterizer_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lr_pkg::lr_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lr_pkg::lr_out_t      out_data_o
);

  logic            push;
  logic            q_ready;
  logic            q_empty;
  logic            pop;
  lr_pkg::lr_cmd_t push_cmd;
  lr_pkg::lr_cmd_t head_cmd;

  // Front end: classify and precompute the line setup.
  lr_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .cmd_o      (push_cmd)
  );

  // Decoupling queue so input and output can stall independently.
  lr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  // Back end: line state, one step per request, registered result.
  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The walker never advances while a result is stalled at the output.
  `LR_ASSERT_IMP(a_no_pop_on_stall, out_valid_o && !out_ready_i, !pop)
  // The endpoint flag only ever rides on a real pixel.
  `LR_ASSERT_IMP(a_last_is_pixel, out_valid_o && out_data_o.last, out_data_o.pixel_valid)
  // A result without a pixel carries all-zero fields.
  `LR_ASSERT_IMP(a_idle_result_zero, out_valid_o && !out_data_o.pixel_valid,
                 out_data_o.pixel_x == '0 && out_data_o.pixel_y == '0 &&
                 out_data_o.pixel_color == '0)
  // A request taken while the queue is empty and the output is free is loaded
  // into the output register at the following edge.
  `LR_ASSERT_IMP(a_one_cycle_latency,
                 $past(in_valid_i && in_ready_o && q_empty && (!out_valid_o || out_ready_i), 2),
                 out_valid_o)

endmodule

`default_nettype wire

// ===== src/lr_front.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts requests and precomputes deltas, step signs, initial error and color.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_front (
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lr_pkg::lr_in_t in_data_i,
  output logic                push_o,
  input  wire logic           q_ready_i,
  output lr_pkg::lr_cmd_t     cmd_o
);

  lr_pkg::coord_t dx, dy;
  lr_pkg::err_t   err_init;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    dx = (in_data_i.x_end > in_data_i.x_start) ? (in_data_i.x_end - in_data_i.x_start)
                                               : (in_data_i.x_start - in_data_i.x_end);
    dy = (in_data_i.y_end > in_data_i.y_start) ? (in_data_i.y_end - in_data_i.y_start)
                                               : (in_data_i.y_start - in_data_i.y_end);
    // Larger delta halved; negated when the line is y-major or diagonal.
    if (dx > dy) begin
      err_init = $signed({2'b00, dx >> 1});
    end else begin
      err_init = -$signed({2'b00, dy >> 1});
    end
  end

  always_comb begin
    cmd_o.op         = in_data_i.op;
    cmd_o.x_start    = in_data_i.x_start;
    cmd_o.y_start    = in_data_i.y_start;
    cmd_o.x_end      = in_data_i.x_end;
    cmd_o.y_end      = in_data_i.y_end;
    cmd_o.delta_x    = dx;
    cmd_o.delta_y    = dy;
    cmd_o.step_x_neg = !(in_data_i.x_start < in_data_i.x_end);
    cmd_o.step_y_neg = !(in_data_i.y_start < in_data_i.y_end);
    cmd_o.error_init = err_init;
    cmd_o.color      = {in_data_i.rgb_color[23:19], in_data_i.rgb_color[15:10],
                        in_data_i.rgb_color[7:3]};
  end

endmodule

`default_nettype wire

// ===== src/lr_queue.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer request queue
// Two-entry queue between the front end and the pixel walker.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lr_pkg::lr_cmd_t push_data_i,
  output logic                 ready_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output lr_pkg::lr_cmd_t      head_o
);

  lr_pkg::lr_cmd_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/lr_back.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer pixel walker
// Holds the line state, takes one Bresenham step per request, registers output.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire lr_pkg::lr_cmd_t cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lr_pkg::lr_out_t      out_data_o
);

  lr_pkg::coord_t                cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  lr_pkg::coord_t                goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  lr_pkg::coord_t                dx_q, dx_d, dy_q, dy_d;
  logic                          sxn_q, sxn_d, syn_q, syn_d;
  lr_pkg::err_t                  err_q, err_d;
  logic [lr_pkg::COLOR_BITS-1:0] color_q, color_d;
  logic                          active_q, active_d;
  logic                          out_valid_q;
  lr_pkg::lr_out_t               out_q, out_d;

  lr_pkg::err_t dx_s, dy_s;
  logic         move_x, move_y, at_end;

  assign pop_o       = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    err_d    = err_q;
    color_d  = color_q;
    active_d = active_q;
    dx_s     = $signed({2'b00, dx_q});
    dy_s     = $signed({2'b00, dy_q});
    move_x   = err_q > -dx_s;
    move_y   = err_q < dy_s;
    out_d    = '0;

    if (cmd_i.op == lr_pkg::OP_START) begin
      cur_x_d  = cmd_i.x_start;
      cur_y_d  = cmd_i.y_start;
      goal_x_d = cmd_i.x_end;
      goal_y_d = cmd_i.y_end;
      dx_d     = cmd_i.delta_x;
      dy_d     = cmd_i.delta_y;
      sxn_d    = cmd_i.step_x_neg;
      syn_d    = cmd_i.step_y_neg;
      err_d    = cmd_i.error_init;
      color_d  = cmd_i.color;
    end else if (active_q) begin
      err_d = err_q - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
      if (move_x) begin
        cur_x_d = sxn_q ? (cur_x_q - lr_pkg::COORD_BITS'(1))
                        : (cur_x_q + lr_pkg::COORD_BITS'(1));
      end
      if (move_y) begin
        cur_y_d = syn_q ? (cur_y_q - lr_pkg::COORD_BITS'(1))
                        : (cur_y_q + lr_pkg::COORD_BITS'(1));
      end
    end

    at_end = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);

    // An advance with no line in progress yields an all-zero result.
    if ((cmd_i.op == lr_pkg::OP_START) || active_q) begin
      active_d          = !at_end;
      out_d.pixel_valid = 1'b1;
      out_d.pixel_x     = cur_x_d;
      out_d.pixel_y     = cur_y_d;
      out_d.pixel_color = color_d;
      out_d.last        = at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sxn_q       <= 1'b0;
      syn_q       <= 1'b0;
      err_q       <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        goal_x_q <= goal_x_d;
        goal_y_q <= goal_y_d;
        dx_q     <= dx_d;
        dy_q     <= dy_d;
        sxn_q    <= sxn_d;
        syn_q    <= syn_d;
        err_q    <= err_d;
        color_q  <= color_d;
        active_q <= active_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== test/line_rasterizer_checker.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer pixel checker
// Watches both channels, predicts each pixel with its own Bresenham walker and
// compares every result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_rasterizer_checker import lr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_ready_i,
  input  wire lr_in_t  in_data_i,
  input  wire logic    out_valid_i,
  input  wire logic    out_ready_i,
  input  wire lr_out_t out_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  // Walker state, cleared at time zero to match the block's own reset state.
  coord_t                pos_x, pos_y, end_x, end_y, run_x, run_y;
  logic                  x_down, y_down, drawing;
  err_t                  bias;
  logic [COLOR_BITS-1:0] color565;

  lr_out_t pixel_q[$];

  initial begin
    pos_x = '0; pos_y = '0; end_x = '0; end_y = '0; run_x = '0; run_y = '0;
    x_down = 1'b0; y_down = 1'b0; drawing = 1'b0; bias = '0; color565 = '0;
  end

  function automatic lr_out_t next_pixel(lr_in_t r);
    lr_out_t o;
    int      e, acc, dx, dy;
    o = '0;
    if (r.op == OP_START) begin
      run_x    = (r.x_end > r.x_start) ? r.x_end - r.x_start : r.x_start - r.x_end;
      run_y    = (r.y_end > r.y_start) ? r.y_end - r.y_start : r.y_start - r.y_end;
      x_down   = (r.x_start < r.x_end) ? 1'b0 : 1'b1;
      y_down   = (r.y_start < r.y_end) ? 1'b0 : 1'b1;
      dx       = run_x;
      dy       = run_y;
      bias     = err_t'((dx > dy) ? dx / 2 : -(dy / 2));
      color565 = {r.rgb_color[23:19], r.rgb_color[15:10], r.rgb_color[7:3]};
      pos_x    = r.x_start;
      pos_y    = r.y_start;
      end_x    = r.x_end;
      end_y    = r.y_end;
    end else if (!drawing) begin
      return o;
    end else begin
      e   = bias;
      acc = e;
      dx  = run_x;
      dy  = run_y;
      if (e > -dx) begin
        acc   = acc - dy;
        pos_x = x_down ? pos_x - coord_t'(1) : pos_x + coord_t'(1);
      end
      if (e < dy) begin
        acc   = acc + dx;
        pos_y = y_down ? pos_y - coord_t'(1) : pos_y + coord_t'(1);
      end
      bias = err_t'(acc);
    end
    o.pixel_valid = 1'b1;
    o.pixel_x     = pos_x;
    o.pixel_y     = pos_y;
    o.pixel_color = color565;
    o.last        = (pos_x == end_x) && (pos_y == end_y);
    drawing       = !o.last;
    return o;
  endfunction

  always @(posedge clk_i) begin
    lr_out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: pixel result with nothing outstanding: %h", $realtime, out_data_i);
          end
          fail_count_o = fail_count_o + 1;
        end else begin
          want = pixel_q.pop_front();
          if (want.pixel_valid !== out_data_i.pixel_valid ||
              want.pixel_x !== out_data_i.pixel_x ||
              want.pixel_y !== out_data_i.pixel_y ||
              want.pixel_color !== out_data_i.pixel_color ||
              want.last !== out_data_i.last) begin
            if (fail_count_o < 10) begin
              $write("%0t: pixel mismatch: expected v=%b x=%0d y=%0d c=%h last=%b,",
                     $realtime, want.pixel_valid, want.pixel_x, want.pixel_y,
                     want.pixel_color, want.last);
              $display(" got v=%b x=%0d y=%0d c=%h last=%b",
                       out_data_i.pixel_valid, out_data_i.pixel_x, out_data_i.pixel_y,
                       out_data_i.pixel_color, out_data_i.last);
            end
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pixel_q.push_back(next_pixel(in_data_i));
      end
      pending_o = pixel_q.size();
    end
  end

endmodule

// ===== test/line_rasterizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives directed and random line requests with random idling on both sides,
// and leaves prediction and comparison to the pixel checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_rasterizer_top_tb;
  import lr_pkg::*;

  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int ITEM_GOAL  = 1200;
  localparam int HOLD_LEN   = 100;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    req_valid = 1'b0;
  logic    req_ready;
  lr_in_t  req_data  = '0;
  logic    pix_valid;
  logic    pix_ready = 1'b0;
  lr_out_t pix_data;

  int      fail_count;
  int      pending;

  // Stimulus control for the two driving processes. When burst is
  // set the sender offers requests back to back; hold_off asks the receiver
  // for one long stall so the request queue fills and in_ready_o drops.
  bit      burst    = 1'b0;
  bit      hold_off = 1'b0;
  int      sent     = 0;

  always #5 clk = ~clk;

  line_rasterizer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_data),
    .out_valid_o (pix_valid),
    .out_ready_i (pix_ready),
    .out_data_o  (pix_data)
  );

  line_rasterizer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_data_i    (req_data),
    .out_valid_i  (pix_valid),
    .out_ready_i  (pix_ready),
    .out_data_i   (pix_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // A request with every field random. Advance requests reuse this, so the
  // endpoint and color fields they carry are noise the block must ignore.
  function automatic lr_in_t random_req();
    lr_in_t r;
    r.op        = lr_op_e'($urandom_range(0, 1));
    r.x_start   = coord_t'($urandom);
    r.y_start   = coord_t'($urandom);
    r.x_end     = coord_t'($urandom);
    r.y_end     = coord_t'($urandom);
    r.rgb_color = RGB_BITS'($urandom);
    return r;
  endfunction

  // A coordinate within reach of c, clamped to the screen so the walk never
  // needs to wrap.
  function automatic coord_t near(coord_t c, int reach);
    int v;
    v = $urandom_range(0, 2 * reach);
    v = v + c - reach;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // Number of advances after the start pixel until the endpoint is reached.
  function automatic int line_span(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    int ax, ay;
    ax = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay = (y1 > y0) ? y1 - y0 : y0 - y1;
    return (ax > ay) ? ax : ay;
  endfunction

  // Offers one request. The call starts and ends at a falling edge; valid
  // stays high with the payload unchanged until the block takes it.
  task automatic send_req(input lr_in_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    sent++;
  endtask

  // One start request followed by a number of advance requests. A count equal
  // to the span walks the whole line; fewer leave it unfinished, more run into
  // advances with no line in progress.
  task automatic draw_line(input coord_t x0, input coord_t y0, input coord_t x1,
                           input coord_t y1, input logic [RGB_BITS-1:0] rgb,
                           input int n_adv);
    lr_in_t r;
    r           = random_req();
    r.op        = OP_START;
    r.x_start   = x0;
    r.y_start   = y0;
    r.x_end     = x1;
    r.y_end     = y1;
    r.rgb_color = rgb;
    send_req(r);
    repeat (n_adv) begin
      r    = random_req();
      r.op = OP_ADVANCE;
      send_req(r);
    end
  endtask

  // Stops offering and waits until every predicted pixel has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    lr_in_t r;
    coord_t x0, y0, x1, y1;
    int     kind, reach, span, n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. An advance straight out of reset has no line to walk.
    r    = random_req();
    r.op = OP_ADVANCE;
    send_req(r);
    // Start and end the same: a single pixel with last set, and the advance
    // after it again finds no line in progress.
    draw_line(10'd5, 10'd5, 10'd5, 10'd5, 24'hFFFFFF, 1);
    // Corner-to-corner diagonal, dropped after two steps by a new start that
    // runs along the opposite diagonal.
    draw_line(10'd0, 10'd0, 10'd1023, 10'd1023, 24'h000000, 2);
    draw_line(10'd1023, 10'd0, 10'd0, 10'd1023, 24'hF80408, 2);
    // Steep line: the initial error comes from the row delta and is negative.
    draw_line(10'd10, 10'd20, 10'd11, 10'd24, 24'hA5A5A5, 4);
    // Flat and upright lines, both walking toward smaller values; the axis
    // that does not change is flagged negative but never moves.
    draw_line(10'd1023, 10'd1023, 10'd1020, 10'd1023, 24'h5A5A5A, 3);
    draw_line(10'd0, 10'd3, 10'd0, 10'd0, 24'h07F8E0, 3);

    // Back pressure: the receiver stalls for a long stretch while requests
    // keep coming without gaps, so the queue fills and the input stalls.
    hold_off = 1'b1;
    burst    = 1'b1;
    draw_line(10'd100, 10'd200, 10'd130, 10'd190, 24'h123456, 30);
    burst    = 1'b0;
    drain();

    // Random part: mostly whole short lines with random content, a few long
    // ones, some cut short or overrun, and some plain noise. A line that would
    // run past the request budget is cut short.
    while (sent < ITEM_GOAL) begin
      kind  = $urandom_range(0, 99);
      burst = ($urandom_range(0, 4) == 0);
      if (kind < 8) begin
        send_req(random_req());
      end else begin
        reach = (kind == 8) ? COORD_MAX : ((kind < 24) ? 63 : 12);
        x0    = coord_t'($urandom);
        y0    = coord_t'($urandom);
        x1    = near(x0, reach);
        y1    = near(y0, reach);
        if ($urandom_range(0, 9) == 0) begin
          y1 = y0;
        end else if ($urandom_range(0, 9) == 0) begin
          x1 = x0;
        end
        span = line_span(x0, y0, x1, y1);
        n    = span;
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(0, span);
        end else if ($urandom_range(0, 9) == 0) begin
          n = span + 1;
        end
        if (n > ITEM_GOAL - sent) begin
          n = ITEM_GOAL - sent;
        end
        draw_line(x0, y0, x1, y1, RGB_BITS'($urandom), n);
      end
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end
    end

    burst = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: draws a stall before each result, with stretches of no stalls,
  // and takes the long hold-off once when the sender asks for it.
  initial begin : sink
    int gap, taken;
    bit fast;
    taken = 0;
    fast  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) begin
        fast = ($urandom_range(0, 3) == 0);
      end
      gap = fast ? 0 : $urandom_range(0, 14);
      if (hold_off) begin
        gap      = HOLD_LEN;
        hold_off = 1'b0;
      end
      if (gap > 0) begin
        pix_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pix_ready <= 1'b1;
      do @(posedge clk); while (!pix_valid);
      @(negedge clk);
      taken++;
    end
  end

  // Generous upper bound well beyond the slowest correct run.
  initial begin : watchdog
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
